// File: hdl/assert_macros.svh
// Assertion macros shared by the noise block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VNZ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vnz check failed");

// Next-cycle implication, checked outside reset.
`define VNZ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vnz check failed");

`endif

// File: hdl/vnz_pkg.sv
// Constants, register codes and blend table builder for the noise block.
package vnz_pkg;

  localparam logic [31:0] HASH_MUL_X = 32'd93157;
  localparam logic [31:0] HASH_MUL_Y = 32'd75319;
  localparam logic [31:0] MT_MUL = 32'd1812433253;
  localparam logic [8:0] MT_STEPS = 9'd397;
  localparam logic [31:0] MT_MATRIX_A = 32'h9908B0DF;
  localparam logic [31:0] MT_TEMPER_B = 32'h9D2C5680;
  localparam logic [31:0] MT_TEMPER_C = 32'hEFC60000;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_OCTAVES = 2'd1;
  localparam logic [1:0] REG_ROUGHNESS = 2'd2;
  localparam logic [1:0] REG_AMPLITUDE = 2'd3;

  // One entry of the sin^2 blend table, Q1.16 (0 .. 65536).
  function automatic logic [16:0] blend_entry(input int unsigned k, input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sq;
    longint sum;
    longint q;
    int n;
    x = (HALF_PI_Q30 * longint'(k)) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 4; n++) begin
      term = (term * x2) >> 30;
      // Divide by (2n)(2n+1): drop the power of two, then take the exact reciprocal.
      case (n)
        1: term = ((term >> 1) * 64'd2863311531) >> 33;
        2: term = ((term >> 2) * 64'd3435973837) >> 34;
        3: term = ((term >> 1) * 64'd3272356036) >> 36;
        default: term = ((term >> 3) * 64'd3817748708) >> 35;
      endcase
      if (n[0]) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    sq = (longint'(sum) * longint'(sum)) >> 30;
    q = (longint'(sq) + 8192) >>> 14;
    if (q > 65536) q = 65536;
    if (k == 0) q = 0;
    if (k == (32'd1 << bits)) q = 65536;
    return 17'(q);
  endfunction

endpackage

// File: hdl/vnz_blend.sv
// Cosine blend weight: table lookup with linear interpolation.
module vnz_blend import vnz_pkg::*; #(
  parameter int COS_TABLE_BITS = 8
) (
  input  logic [15:0] frac,
  output logic [16:0] weight
);

  localparam int SUB_BITS = 16 - COS_TABLE_BITS;
  localparam int TAB_N = 1 << COS_TABLE_BITS;

  logic [16:0] tab [TAB_N + 1];

  for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
    assign tab[k] = blend_entry(k, COS_TABLE_BITS);
  end

  logic [COS_TABLE_BITS-1:0] idx;
  logic [SUB_BITS-1:0] rem;
  logic [16:0] t0;
  logic [16:0] t1;
  logic signed [17:0] d;
  logic signed [17+SUB_BITS+1:0] prod;
  logic signed [17+SUB_BITS+1:0] prod_sh;

  assign idx = frac[15:SUB_BITS];
  assign rem = frac[SUB_BITS-1:0];
  assign t0 = tab[{1'b0, idx}];
  assign t1 = tab[{1'b0, idx} + (COS_TABLE_BITS+1)'(1)];
  assign d = $signed({1'b0, t1}) - $signed({1'b0, t0});
  assign prod = (SUB_BITS+19)'(d) * $signed((SUB_BITS+19)'({1'b0, rem}));
  assign prod_sh = prod >>> SUB_BITS;
  assign weight = t0 + prod_sh[16:0];

endmodule

// File: hdl/octave_value_noise_2d_top.sv
// Top level: octave-summed 2D value noise with a shared multiplier and sequencer.
// Each octave hashes 16 lattice points; each runs the 397-step seeding loop of the
// generator through the single shared multiplier.
// One word at a time: busy stays high until the result strobe; done lasts one cycle.
// Synchronous active-high reset clears the sequencer and loads register defaults.
`include "assert_macros.svh"

module octave_value_noise_2d_top import vnz_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  output logic               done,
  output logic signed [31:0] noise_value,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_SETUP   = 14'b00000000000010,
    S_HASH_X  = 14'b00000000000100,
    S_HASH_Y  = 14'b00000000001000,
    S_MT_STEP = 14'b00000000010000,
    S_MT_OUT  = 14'b00000000100000,
    S_SMOOTH  = 14'b00000001000000,
    S_MIX_A   = 14'b00000010000000,
    S_MIX_B   = 14'b00000100000000,
    S_MIX_C   = 14'b00001000000000,
    S_AMP     = 14'b00010000000000,
    S_ACC     = 14'b00100000000000,
    S_RPOW    = 14'b01000000000000,
    S_FINISH  = 14'b10000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [31:0] noise_seed;
  logic [3:0]  octave_count;
  logic [15:0] roughness_q16;
  logic [15:0] base_amplitude_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= '0;
      octave_count <= 4'd4;
      roughness_q16 <= 16'd32768;
      base_amplitude_q8 <= 16'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEED:      noise_seed <= cfg_data;
        REG_OCTAVES:   octave_count <= cfg_data[3:0];
        REG_ROUGHNESS: roughness_q16 <= cfg_data[15:0];
        REG_AMPLITUDE: base_amplitude_q8 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Item working registers.
  logic signed [31:0] cx, cy;
  logic [OCT_W-1:0] n_oct, oct;
  logic [31:0] ix, iy;
  logic [15:0] fx, fy;
  logic [16:0] wx, wy;
  logic [3:0] g;
  logic [31:0] hx, s_seed, prev, m1;
  logic [8:0] mt_i;
  logic signed [36:0] acc [4];
  logic signed [31:0] v [4];
  logic signed [31:0] m12, m34, nv;
  logic [31:0] w;
  logic [16:0] rpow;
  logic signed [33:0] total;

  // Effective octave count, clamped to MAX_OCTAVES.
  logic [OCT_W-1:0] n_eff;
  assign n_eff = (32'(octave_count) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                   : OCT_W'(octave_count);

  // Split both coordinates at this octave's scale.
  logic [4:0] sh;
  logic [32:0] mag_x, mag_y, fsh_x, fsh_y, ish_x, ish_y;
  assign sh = 5'(n_oct - oct - OCT_W'(1));
  assign mag_x = cx[31] ? (33'd0 - 33'(cx)) : 33'(cx);
  assign mag_y = cy[31] ? (33'd0 - 33'(cy)) : 33'(cy);
  assign fsh_x = mag_x >> sh;
  assign fsh_y = mag_y >> sh;
  assign ish_x = mag_x >> (6'd16 + 6'(sh));
  assign ish_y = mag_y >> (6'd16 + 6'(sh));

  vnz_blend #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_blend_x (.frac(fx), .weight(wx));
  vnz_blend #(.COS_TABLE_BITS(COS_TABLE_BITS)) u_blend_y (.frac(fy), .weight(wy));

  // Shared multiplier: one operand pair per state, product captured by that state.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic [31:0] lat_x, lat_y, mt_in;
  logic signed [32:0] diff;

  assign lat_x = ix + {30'd0, g[1:0]} - 32'd1;
  assign lat_y = iy + {30'd0, g[3:2]} - 32'd1;
  assign mt_in = prev ^ (prev >> 30);

  always_comb begin
    diff = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_HASH_X: begin
        mul_a = {2'b00, lat_x};
        mul_b = {2'b00, HASH_MUL_X};
      end
      S_HASH_Y: begin
        mul_a = {2'b00, lat_y};
        mul_b = {2'b00, HASH_MUL_Y};
      end
      S_MT_STEP: begin
        mul_a = {2'b00, mt_in};
        mul_b = {2'b00, MT_MUL};
      end
      S_MIX_A: begin
        diff = 33'(v[1]) - 33'(v[0]);
        mul_a = 34'(diff);
        mul_b = {17'd0, wx};
      end
      S_MIX_B: begin
        diff = 33'(v[3]) - 33'(v[2]);
        mul_a = 34'(diff);
        mul_b = {17'd0, wx};
      end
      S_MIX_C: begin
        diff = 33'(m34) - 33'(m12);
        mul_a = 34'(diff);
        mul_b = {17'd0, wy};
      end
      S_AMP: begin
        mul_a = {18'd0, base_amplitude_q8};
        mul_b = {17'd0, rpow};
      end
      S_ACC: begin
        mul_a = 34'(nv);
        mul_b = {2'b00, w};
      end
      S_RPOW: begin
        mul_a = {17'd0, rpow};
        mul_b = {18'd0, roughness_q16};
      end
      default: ;
    endcase
  end

  assign mul_p = 68'(mul_a) * 68'(mul_b);

  logic [31:0] mt_next;
  assign mt_next = mul_p[31:0] + {23'd0, mt_i};

  // Tempered first output of the generator, mapped to signed Q1.31.
  logic [31:0] ty0, ty1, ty2, ty3, ty4, ty5;
  logic signed [31:0] lat;
  assign ty0 = {s_seed[31], m1[30:0]};
  assign ty1 = prev ^ (ty0 >> 1) ^ (ty0[0] ? MT_MATRIX_A : 32'd0);
  assign ty2 = ty1 ^ (ty1 >> 11);
  assign ty3 = ty2 ^ ((ty2 << 7) & MT_TEMPER_B);
  assign ty4 = ty3 ^ ((ty3 << 15) & MT_TEMPER_C);
  assign ty5 = ty4 ^ (ty4 >> 18);
  assign lat = $signed({~ty5[31], ty5[30:0]});

  // Smoothing kernel contribution of this lattice point to each corner.
  logic [2:0] dxu [4];
  logic [2:0] dyu [4];
  logic       hit [4];
  logic signed [36:0] contrib [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dxu[c] = {1'b0, g[1:0]} - {2'b00, 1'(c % 2)};
      dyu[c] = {1'b0, g[3:2]} - {2'b00, 1'(c / 2)};
      hit[c] = (dxu[c] <= 3'd2) && (dyu[c] <= 3'd2);
      contrib[c] = 37'(lat) <<< (2'(dxu[c] == 3'd1) + 2'(dyu[c] == 3'd1));
    end
  end

  logic signed [33:0] oct_add;
  logic signed [67:0] acc_sh;
  assign acc_sh = mul_p >>> 39;
  assign oct_add = acc_sh[33:0];

  logic signed [67:0] mix_sh;
  assign mix_sh = mul_p >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cx <= coord_x;
            cy <= coord_y;
            n_oct <= n_eff;
            oct <= '0;
            rpow <= 17'd65536;
            total <= '0;
            state <= (n_eff == '0) ? S_FINISH : S_SETUP;
          end
        end
        S_SETUP: begin
          ix <= cx[31] ? (32'd0 - ish_x[31:0]) : ish_x[31:0];
          iy <= cy[31] ? (32'd0 - ish_y[31:0]) : ish_y[31:0];
          fx <= fsh_x[15:0];
          fy <= fsh_y[15:0];
          g <= '0;
          for (int c = 0; c < 4; c++) acc[c] <= '0;
          state <= S_HASH_X;
        end
        S_HASH_X: begin
          hx <= mul_p[31:0];
          state <= S_HASH_Y;
        end
        S_HASH_Y: begin
          s_seed <= hx + mul_p[31:0] + noise_seed;
          prev <= hx + mul_p[31:0] + noise_seed;
          mt_i <= 9'd1;
          state <= S_MT_STEP;
        end
        S_MT_STEP: begin
          prev <= mt_next;
          if (mt_i == 9'd1) m1 <= mt_next;
          if (mt_i == MT_STEPS) state <= S_MT_OUT;
          else mt_i <= mt_i + 9'd1;
        end
        S_MT_OUT: begin
          for (int c = 0; c < 4; c++) begin
            if (hit[c]) acc[c] <= acc[c] + contrib[c];
          end
          g <= g + 4'd1;
          state <= (g == 4'd15) ? S_SMOOTH : S_HASH_X;
        end
        S_SMOOTH: begin
          for (int c = 0; c < 4; c++) v[c] <= 32'(acc[c] >>> 4);
          state <= S_MIX_A;
        end
        S_MIX_A: begin
          m12 <= v[0] + mix_sh[31:0];
          state <= S_MIX_B;
        end
        S_MIX_B: begin
          m34 <= v[2] + mix_sh[31:0];
          state <= S_MIX_C;
        end
        S_MIX_C: begin
          nv <= m12 + mix_sh[31:0];
          state <= S_AMP;
        end
        S_AMP: begin
          w <= mul_p[31:0];
          state <= S_ACC;
        end
        S_ACC: begin
          total <= total + oct_add;
          state <= S_RPOW;
        end
        S_RPOW: begin
          rpow <= mul_p[32:16];
          oct <= oct + OCT_W'(1);
          state <= (oct + OCT_W'(1) == n_oct) ? S_FINISH : S_SETUP;
        end
        S_FINISH: begin
          // Saturate to the signed 32-bit range and strobe the word out.
          if (total > 34'sd2147483647) noise_value <= 32'sh7FFFFFFF;
          else if (total < -34'sd2147483648) noise_value <= 32'sh80000000;
          else noise_value <= total[31:0];
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `VNZ_ASSERT_IMP(a_state_onehot, clk, rst, 1'b1, $onehot(state))
  `VNZ_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `VNZ_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `VNZ_ASSERT_NXT(a_finish_done, clk, rst, state == S_FINISH, done)

endmodule

// File: sim/octave_value_noise_2d_top_tb.sv
// Testbench for the octave value noise block: directed table, random phases, self-checked.
`timescale 1ns / 100ps

module octave_value_noise_2d_top_tb import vnz_pkg::*; ();

  localparam int OCT_LIMIT = 8;
  localparam int TAB_BITS = 8;
  localparam int TAB_STEPS = 1 << TAB_BITS;
  localparam int FRAC_SUB = 16 - TAB_BITS;

  typedef longint unsigned u64_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] coord_x = '0;
  logic signed [31:0] coord_y = '0;
  logic done;
  logic signed [31:0] noise_value;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_SEED;
  logic [31:0] cfg_data = '0;

  octave_value_noise_2d_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .done(done), .noise_value(noise_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Generous bound: far beyond the slowest legal run of all items.
  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  // Shadow copy of the configuration registers.
  logic [31:0] seed_q = 32'd0;
  logic [3:0] octaves_q = 4'd4;
  logic [15:0] rough_q = 16'd32768;
  logic [15:0] amp_q = 16'd256;

  longint cos_tab [0:TAB_STEPS];
  logic signed [31:0] expected_noise [$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit idle_on = 1'b1;

  // sin^2(pi*t/2) in Q1.16, built with a five-term Taylor series in Q30.
  function automatic void build_cos_tab();
    longint unsigned x, x2, term, sq;
    longint sum, q;
    for (int k = 0; k <= TAB_STEPS; k++) begin
      x = (HALF_PI_Q30 * longint'(k)) >> TAB_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 4; n++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      sq = (u64_t'(sum) * u64_t'(sum)) >> 30;
      q = (longint'(sq) + 8192) >>> 14;
      if (q > 65536) q = 65536;
      cos_tab[k] = q;
    end
    cos_tab[0] = 0;
    cos_tab[TAB_STEPS] = 65536;
  endfunction

  function automatic longint cos_weight(logic [15:0] frac);
    int idx;
    longint rem, d;
    idx = frac >> FRAC_SUB;
    rem = frac & ((1 << FRAC_SUB) - 1);
    d = cos_tab[idx + 1] - cos_tab[idx];
    return cos_tab[idx] + ((d * rem) >>> FRAC_SUB);
  endfunction

  // First tempered output of a freshly seeded Mersenne twister.
  function automatic logic [31:0] twister_first(logic [31:0] s);
    logic [31:0] prev, m1, y;
    prev = s;
    m1 = '0;
    for (int i = 1; i <= 397; i++) begin
      prev = 32'd1812433253 * (prev ^ (prev >> 30)) + 32'(i);
      if (i == 1) m1 = prev;
    end
    y = (s & 32'h8000_0000) | (m1 & 32'h7FFF_FFFF);
    y = prev ^ (y >> 1) ^ (y[0] ? 32'h9908_B0DF : 32'h0);
    y ^= y >> 11;
    y ^= (y << 7) & 32'h9D2C_5680;
    y ^= (y << 15) & 32'hEFC6_0000;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic longint lattice_q31(int x, int y);
    logic [31:0] h;
    h = 32'(x) * 32'd93157 + 32'(y) * 32'd75319 + seed_q;
    return longint'({32'd0, twister_first(h)}) - 64'sd2147483648;
  endfunction

  function automatic longint smooth_q31(int x, int y);
    longint c, s, m;
    c = lattice_q31(x - 1, y - 1) + lattice_q31(x + 1, y - 1)
      + lattice_q31(x - 1, y + 1) + lattice_q31(x + 1, y + 1);
    s = lattice_q31(x - 1, y) + lattice_q31(x + 1, y)
      + lattice_q31(x, y - 1) + lattice_q31(x, y + 1);
    m = lattice_q31(x, y);
    return (c + 2 * s + 4 * m) >>> 4;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  // Split a Q16.16 value scaled down by 2^s: integer part toward zero, fraction magnitude.
  function automatic void split_coord(longint v, int s, output int ip, output logic [15:0] f);
    longint unsigned mag, im;
    int fb;
    mag = (v < 0) ? u64_t'(-v) : u64_t'(v);
    fb = 16 + s;
    im = mag >> fb;
    f = 16'((mag & ((64'd1 << fb) - 1)) >> s);
    ip = (v < 0) ? -int'(im) : int'(im);
  endfunction

  function automatic logic signed [31:0] octave_noise_sum(logic signed [31:0] x,
                                                          logic signed [31:0] y);
    int n, s, ix, iy;
    logic [15:0] fx, fy;
    longint wx, wy, nv, w, total;
    longint unsigned rpow;
    n = (octaves_q > OCT_LIMIT) ? OCT_LIMIT : int'(octaves_q);
    rpow = 65536;
    total = 0;
    for (int i = 0; i < n; i++) begin
      s = n - 1 - i;
      split_coord(longint'(x), s, ix, fx);
      split_coord(longint'(y), s, iy, fy);
      wx = cos_weight(fx);
      wy = cos_weight(fy);
      nv = blend(blend(smooth_q31(ix, iy), smooth_q31(ix + 1, iy), wx),
                 blend(smooth_q31(ix, iy + 1), smooth_q31(ix + 1, iy + 1), wx), wy);
      w = longint'(u64_t'(amp_q) * rpow);
      total += (nv * w) >>> 39;
      rpow = (rpow * rough_q) >> 16;
    end
    if (total > 64'sd2147483647) total = 64'sd2147483647;
    if (total < -64'sd2147483648) total = -64'sd2147483648;
    return 32'(total);
  endfunction

  // Check each strobed word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_noise.size() == 0) begin
        $error("noise_value: unexpected word, actual %0d", noise_value);
        errors++;
      end else begin
        if (noise_value !== expected_noise[0]) begin
          $error("noise_value: expected %0d, actual %0d", expected_noise[0], noise_value);
          errors++;
        end
        void'(expected_noise.pop_front());
        words_checked++;
      end
    end
  end

  // Hold until every predicted word has come back.
  task automatic drain();
    while (expected_noise.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SEED: seed_q = data;
      REG_OCTAVES: octaves_q = data[3:0];
      REG_ROUGHNESS: rough_q = data[15:0];
      default: amp_q = data[15:0];
    endcase
  endtask

  // Rewrite all four registers while idle; junk upper bits, not on the seed, test masking.
  task automatic configure(logic [31:0] seed, logic [3:0] oct, logic [15:0] rough,
                           logic [15:0] amp);
    drain();
    write_reg(REG_SEED, seed);
    write_reg(REG_OCTAVES, {28'($urandom()), oct});
    write_reg(REG_ROUGHNESS, {16'($urandom()), rough});
    write_reg(REG_AMPLITUDE, {16'($urandom()), amp});
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one word; start stays high across back-to-back words.
  task automatic send_word(logic signed [31:0] x, logic signed [31:0] y);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (busy);
    expected_noise.push_back(octave_noise_sum(x, y));
    words_sent++;
  endtask

  typedef struct {
    logic [31:0] seed;
    logic [3:0] oct;
    logic [15:0] rough;
    logic [15:0] amp;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit typed;
    logic signed [31:0] value;
  } stim_row_t;

  // Directed rows: reset settings, zero octaves, clamped octave count, extremes.
  stim_row_t dir_rows [14] = '{
    '{32'd0, 4'd4, 16'd32768, 16'd256, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 32'sd0},
    '{32'd0, 4'd4, 16'd32768, 16'd256, 32'sh0001_8000, 32'sh0002_4000, 1'b0, 32'sd0},
    '{32'd0, 4'd4, 16'd32768, 16'd256, -32'sh0001_8000, -32'sh0000_C000, 1'b0, 32'sd0},
    '{32'd7, 4'd0, 16'd32768, 16'd256, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'sd0},
    '{32'd7, 4'd0, 16'd32768, 16'd256, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 32'sd0},
    '{32'd7, 4'd0, 16'd32768, 16'd256, 32'sh1234_5678, -32'sh0BAD_F00D, 1'b1, 32'sd0},
    '{32'hFFFF_FFFF, 4'd15, 16'd65535, 16'd65535, 32'sh0123_4567, -32'sh0765_4321,
      1'b0, 32'sd0},
    '{32'hFFFF_FFFF, 4'd1, 16'd0, 16'd65535, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
    '{32'hFFFF_FFFF, 4'd1, 16'd0, 16'd65535, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0},
    '{32'hFFFF_FFFF, 4'd1, 16'd0, 16'd65535, 32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 32'sd0},
    '{32'hFFFF_FFFF, 4'd1, 16'd0, 16'd65535, 32'sh0000_FFFF, 32'shFFFF_0000, 1'b0, 32'sd0},
    '{32'hFFFF_FFFF, 4'd1, 16'd0, 16'd65535, 32'sh0000_8000, -32'sh0000_8000, 1'b0, 32'sd0},
    '{32'h8000_0000, 4'd2, 16'd65535, 16'd0, 32'sh0003_0000, 32'sh0005_0000, 1'b0, 32'sd0},
    '{32'h8000_0000, 4'd2, 16'd65535, 16'd1, -32'sh0003_0001, 32'sh0005_FFFF, 1'b0, 32'sd0}
  };

  initial begin
    logic [3:0] oct;
    logic [15:0] rough, amp;
    build_cos_tab();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: reconfigure whenever a row asks for other settings.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].seed != seed_q || dir_rows[r].oct != octaves_q ||
          dir_rows[r].rough != rough_q || dir_rows[r].amp != amp_q) begin
        start <= 1'b0;
        configure(dir_rows[r].seed, dir_rows[r].oct, dir_rows[r].rough, dir_rows[r].amp);
      end
      send_word(dir_rows[r].x, dir_rows[r].y);
      // Typed rows override the prediction with the value read off directly.
      if (dir_rows[r].typed) expected_noise[$] = dir_rows[r].value;
    end

    // Random phases: few octaves keep the run short; the last phase runs without gaps.
    for (int ph = 0; ph < 5; ph++) begin
      oct = (ph == 2) ? 4'd3 : 4'($urandom_range(0, 2));
      rough = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
      amp = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
      start <= 1'b0;
      configure($urandom(), oct, rough, amp);
      idle_on = (ph != 4);
      for (int k = 0; k < 20; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_word($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000, $urandom());
        else
          send_word($urandom(), $urandom());
        // Pause until the block has caught up, once per phase.
        if (k == 10) begin
          start <= 1'b0;
          drain();
        end
      end
    end
    start <= 1'b0;

    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d words across register settings of 0 to 15 octaves,", words_sent);
    $display("extreme seeds, roughness and amplitude; %0d words checked.", words_checked);
    if (errors == 0 && expected_noise.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
